@@ src/escape_count_colorizer_macros.svh @@
// assertion macros shared by the colourizer modules
// needs clk and rst_n in the scope of each use
`ifndef ESCAPE_COUNT_COLORIZER_MACROS_SVH
`define ESCAPE_COUNT_COLORIZER_MACROS_SVH

// same-cycle implication
`define ECC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ecc_pkg.sv @@
// types, constants and helper functions of the escape count colourizer
// no dependencies
package ecc_pkg;

    localparam logic [2:0] MODE_LINEAR = 3'd0;
    localparam logic [2:0] MODE_LOG    = 3'd1;
    localparam logic [2:0] MODE_SMOOTH = 3'd2;
    localparam logic [2:0] MODE_HIST   = 3'd3;
    localparam logic [2:0] MODE_CYCLIC = 3'd4;

    localparam logic REG_COLOR_MODE = 1'b0;
    localparam logic REG_MAX_ITER   = 1'b1;

    localparam int DIV_QBITS = 17;
    localparam int NUM_W     = 37;
    localparam int DEN_W     = 20;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        KIND_LIN,
        KIND_LOG,
        KIND_SMOOTH,
        KIND_CYC
    } kind_t;

    typedef struct packed {
        logic [2:0]  color_mode;
        logic [15:0] max_iterations;
    } cfg_t;

    typedef struct packed {
        logic       black;
        kind_t      kind;
        logic [3:0] cyc_idx;
    } tag_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             ovf;
        tag_t             tag;
    } div_in_t;

    typedef struct packed {
        logic [DIV_QBITS-1:0] quo;
        logic                 ovf;
        tag_t                 tag;
    } div_out_t;

    localparam logic [7:0] CYC_R [16] = '{8'd128, 8'd176, 8'd217, 8'd245, 8'd255, 8'd245,
        8'd217, 8'd176, 8'd128, 8'd79, 8'd38, 8'd10, 8'd1, 8'd10, 8'd38, 8'd79};
    localparam logic [7:0] CYC_G [16] = '{8'd237, 8'd205, 8'd160, 8'd111, 8'd64, 8'd27,
        8'd5, 8'd2, 8'd18, 8'd50, 8'd95, 8'd144, 8'd191, 8'd228, 8'd250, 8'd253};
    localparam logic [7:0] CYC_B [16] = '{8'd18, 8'd2, 8'd5, 8'd27, 8'd64, 8'd111,
        8'd160, 8'd205, 8'd237, 8'd253, 8'd250, 8'd228, 8'd191, 8'd144, 8'd95, 8'd50};

    function automatic kind_t mode_kind(input logic [2:0] mode);
        kind_t k;
        unique case (mode)
            MODE_LOG:    k = KIND_LOG;
            MODE_SMOOTH: k = KIND_SMOOTH;
            MODE_CYCLIC: k = KIND_CYC;
            default:     k = KIND_LIN;
        endcase
        return k;
    endfunction

    // position of the leading one, zero for a zero word
    function automatic logic [4:0] msb_pos(input logic [31:0] x);
        logic [4:0] p;
        p = '0;
        for (int k = 0; k < 32; k++) begin
            if (x[k]) p = 5'(k);
        end
        return p;
    endfunction

    // fractional part of the piecewise-linear log2, Q.16
    function automatic logic [15:0] log_frac(input logic [31:0] x, input logic [4:0] p);
        logic [31:0] m;
        logic [47:0] v;
        m = x & ~(32'd1 << p);
        v = {m, 16'h0000} >> p;
        return v[15:0];
    endfunction

endpackage

@@ src/ecc_if.sv @@
// pixel word channels of the colourizer: count and magnitude in, rgb out
// no dependencies
interface ecc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] iteration_count;
    logic [31:0] magnitude_squared;

    modport source (output valid, iteration_count, magnitude_squared, input ready);
    modport sink   (input valid, iteration_count, magnitude_squared, output ready);
endinterface

interface ecc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ src/ecc_regs.sv @@
// apb register file: colour mode and iteration limit
// depends on ecc_pkg
module ecc_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ecc_pkg::cfg_t      cfg
);

    logic [2:0]  color_mode_reg, color_mode_next;
    logic [15:0] max_iter_reg, max_iter_next;
    logic        wr;
    logic        idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[2];
    assign pready = 1'b1;

    always_comb
    begin
        color_mode_next = color_mode_reg;
        max_iter_next   = max_iter_reg;
        if (wr)
        begin
            unique case (idx)
                ecc_pkg::REG_COLOR_MODE: color_mode_next = pwdata[2:0];
                ecc_pkg::REG_MAX_ITER:   max_iter_next   = pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ecc_pkg::REG_COLOR_MODE: prdata = {29'd0, color_mode_reg};
            ecc_pkg::REG_MAX_ITER:   prdata = {16'd0, max_iter_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= ecc_pkg::MODE_LINEAR;
            max_iter_reg   <= 16'd256;
        end
        else
        begin
            color_mode_reg <= color_mode_next;
            max_iter_reg   <= max_iter_next;
        end
    end

    assign cfg.color_mode     = color_mode_reg;
    assign cfg.max_iterations = max_iter_reg;

endmodule

@@ src/ecc_front.sv @@
// front stages: log2 of count, limit and magnitude, smooth correction,
// dividend and divisor selection and overflow check; depends on ecc_pkg
module ecc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [15:0]      iteration_count,
    input  logic [31:0]      magnitude_squared,
    input  ecc_pkg::cfg_t    cfg,
    output logic             dout_valid,
    output ecc_pkg::div_in_t dout
);

    // limit log2, static between config writes
    logic [4:0]  pm_reg;
    logic [19:0] lm_reg;
    logic [15:0] den16;

    // stage 1
    logic        v1_reg;
    logic [15:0] i1_reg;
    logic [31:0] mag1_reg;
    logic [4:0]  pi1_reg, pz1_reg;
    // stage 2
    logic        v2_reg;
    logic [15:0] i2_reg;
    logic [19:0] li2_reg, li2_next;
    logic [20:0] lmag2_reg, lmag2_next;
    logic [23:0] lin2_reg, lin2_next;
    logic        big2_reg;
    ecc_pkg::tag_t tag2_reg, tag2_next;
    // stage 3
    logic        v3_reg;
    logic [15:0] i3_reg;
    logic [19:0] li3_reg;
    logic [23:0] lin3_reg;
    logic        big3_reg;
    ecc_pkg::tag_t tag3_reg;
    logic [20:0] l2;
    logic [35:0] prod;
    logic [19:0] lnzr3_reg;
    // stage 4
    logic        v4_reg;
    logic [15:0] i4_reg;
    logic [19:0] li4_reg;
    logic [23:0] lin4_reg;
    logic        big4_reg;
    ecc_pkg::tag_t tag4_reg;
    logic [19:0] lnz4_reg, lnz4_next;
    logic [4:0]  pl4_reg;
    // stage 5
    logic        v5_reg;
    logic [15:0] i5_reg;
    logic [19:0] li5_reg;
    logic [23:0] lin5_reg;
    ecc_pkg::tag_t tag5_reg;
    logic [20:0] llnz;
    logic signed [21:0] nu5_reg, nu5_next;
    // stage 6
    logic        v6_reg;
    ecc_pkg::tag_t tag6_reg;
    logic [16:0] ip1;
    logic [34:0] s;
    logic [ecc_pkg::NUM_W-1:0] num6_reg, num6_next;
    logic [ecc_pkg::DEN_W-1:0] den6_reg, den6_next;
    // stage 7
    logic        v7_reg;
    ecc_pkg::div_in_t d7_reg, d7_next;

    assign den16 = (cfg.max_iterations == 16'd0) ? 16'd1 : cfg.max_iterations;

    always_ff @(posedge clk)
    begin
        pm_reg <= ecc_pkg::msb_pos({16'd0, cfg.max_iterations});
        lm_reg <= {pm_reg[3:0], ecc_pkg::log_frac({16'd0, cfg.max_iterations}, pm_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        li2_next   = {pi1_reg[3:0], ecc_pkg::log_frac({16'd0, i1_reg}, pi1_reg)};
        lmag2_next = {pz1_reg, ecc_pkg::log_frac(mag1_reg, pz1_reg)};
        lin2_next  = 24'(i1_reg) * 24'd255;
        tag2_next.black   = (i1_reg == cfg.max_iterations);
        tag2_next.kind    = ecc_pkg::mode_kind(cfg.color_mode);
        tag2_next.cyc_idx = i1_reg[3:0];
    end

    // ln|z| from log2 of |z|^2 in Q8.24
    assign l2   = lmag2_reg - 21'h18_0000;
    assign prod = 36'(l2) * 36'd22713;

    assign lnz4_next = (lnzr3_reg == 20'd0) ? 20'd1 : lnzr3_reg;

    assign llnz     = {pl4_reg, ecc_pkg::log_frac({12'd0, lnz4_reg}, pl4_reg)};
    assign nu5_next = big4_reg ? ($signed({1'b0, llnz}) - 22'sd1048576) : 22'sd0;

    assign ip1 = {1'b0, i5_reg} + 17'd1;
    assign s   = {2'b00, ip1, 16'h0000} - {{13{nu5_reg[21]}}, nu5_reg};

    always_comb
    begin
        num6_next = '0;
        den6_next = {4'd0, den16};
        unique case (tag5_reg.kind)
            ecc_pkg::KIND_LIN:
                num6_next = ecc_pkg::NUM_W'(lin5_reg);
            ecc_pkg::KIND_LOG:
            begin
                num6_next = ecc_pkg::NUM_W'({li5_reg, 16'h0000});
                // zero limit log: a count of zero or one gives ratio zero, the rest overflow
                den6_next = (lm_reg == 20'd0) ? 20'd1 : lm_reg;
            end
            ecc_pkg::KIND_SMOOTH:
                // non-positive smooth value gives ratio zero
                num6_next = (!s[34] && (s != 35'd0)) ? ecc_pkg::NUM_W'(s[33:0]) : '0;
            ecc_pkg::KIND_CYC:
                num6_next = '0;
        endcase
    end

    always_comb
    begin
        d7_next.num = num6_reg;
        d7_next.den = den6_reg;
        d7_next.ovf = (num6_reg >= {den6_reg, 17'd0}) && (num6_reg != '0);
        d7_next.tag = tag6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_reg    <= iteration_count;
            mag1_reg  <= magnitude_squared;
            pi1_reg   <= ecc_pkg::msb_pos({16'd0, iteration_count});
            pz1_reg   <= ecc_pkg::msb_pos(magnitude_squared);

            i2_reg    <= i1_reg;
            li2_reg   <= li2_next;
            lmag2_reg <= lmag2_next;
            lin2_reg  <= lin2_next;
            big2_reg  <= (mag1_reg > 32'h0100_0000);
            tag2_reg  <= tag2_next;

            i3_reg    <= i2_reg;
            li3_reg   <= li2_reg;
            lin3_reg  <= lin2_reg;
            big3_reg  <= big2_reg;
            tag3_reg  <= tag2_reg;
            lnzr3_reg <= prod[35:16];

            i4_reg    <= i3_reg;
            li4_reg   <= li3_reg;
            lin4_reg  <= lin3_reg;
            big4_reg  <= big3_reg;
            tag4_reg  <= tag3_reg;
            lnz4_reg  <= lnz4_next;
            pl4_reg   <= ecc_pkg::msb_pos({12'd0, lnz4_next});

            i5_reg    <= i4_reg;
            li5_reg   <= li4_reg;
            lin5_reg  <= lin4_reg;
            tag5_reg  <= tag4_reg;
            nu5_reg   <= nu5_next;

            tag6_reg  <= tag5_reg;
            num6_reg  <= num6_next;
            den6_reg  <= den6_next;

            d7_reg    <= d7_next;
        end
    end

    assign dout_valid = v7_reg;
    assign dout       = d7_reg;

endmodule

@@ src/ecc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on ecc_pkg and escape_count_colorizer_macros.svh
`include "escape_count_colorizer_macros.svh"

module ecc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              din_valid,
    input  ecc_pkg::div_in_t  din,
    output logic              dout_valid,
    output ecc_pkg::div_out_t dout
);

    localparam int LAST = ecc_pkg::DIV_QBITS - 1;

    typedef struct packed {
        logic [ecc_pkg::NUM_W-1:0]     rem;
        logic [ecc_pkg::DEN_W-1:0]     den;
        logic [ecc_pkg::DIV_QBITS-1:0] quo;
        logic                          ovf;
        ecc_pkg::tag_t                 tag;
    } div_stage_t;

    div_stage_t                    first_st;
    div_stage_t                    st_reg  [ecc_pkg::DIV_QBITS];
    logic [ecc_pkg::DIV_QBITS-1:0] vld_reg;

    assign first_st.rem = din.num;
    assign first_st.den = din.den;
    assign first_st.quo = '0;
    assign first_st.ovf = din.ovf;
    assign first_st.tag = din.tag;

    for (genvar k = 0; k < ecc_pkg::DIV_QBITS; k++)
    begin : g_stage
        div_stage_t                cur;
        div_stage_t                st_next;
        logic                      vin;
        logic [ecc_pkg::NUM_W-1:0] shd;
        logic                      take;

        if (k == 0)
        begin : g_first
            assign cur = first_st;
            assign vin = din_valid;
        end
        else
        begin : g_next
            assign cur = st_reg[k-1];
            assign vin = vld_reg[k-1];
        end

        assign shd  = ecc_pkg::NUM_W'(cur.den) << (LAST - k);
        assign take = !cur.ovf && (cur.rem >= shd);

        always_comb
        begin
            st_next = cur;
            if (take)
            begin
                st_next.rem          = cur.rem - shd;
                st_next.quo[LAST - k] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= st_next;
        end
    end

    assign dout_valid = vld_reg[LAST];
    assign dout.quo   = st_reg[LAST].quo;
    assign dout.ovf   = st_reg[LAST].ovf;
    assign dout.tag   = st_reg[LAST].tag;

    `ECC_ASSERT_IMP(a_rem_below_den,
        vld_reg[LAST] && !st_reg[LAST].ovf,
        st_reg[LAST].rem < ecc_pkg::NUM_W'(st_reg[LAST].den),
        "divider remainder not below divisor")
    `ECC_ASSERT_NXT(a_ovf_carried,
        en && vld_reg[0] && st_reg[0].ovf,
        st_reg[1].ovf && vld_reg[1],
        "overflow flag lost between divider stages")

endmodule

@@ src/ecc_back.sv @@
// back stages: ratio clamp, hue sector, cubic channel products,
// palette lookup and final colour select; depends on ecc_pkg and macros
`include "escape_count_colorizer_macros.svh"

module ecc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              din_valid,
    input  ecc_pkg::div_out_t din,
    output logic              out_valid,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue
);

    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    ecc_pkg::tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [7:0]    lin1_reg, lin2_reg, lin3_reg, lin4_reg, lin5_reg, lin1_next;
    logic [16:0]   t1_reg, t1_next;

    logic [16:0]   t2_reg, u2_reg, tt2_reg, uu2_reg, x2_reg, u2_next, x2_next;
    logic [2:0]    sec2_reg, sec3_reg, sec4_reg, sec5_reg;
    logic [19:0]   h;
    logic [33:0]   ptt, puu;

    logic [16:0]   t3_reg, u3_reg, ttt3_reg, uut3_reg, uuu3_reg;
    logic [7:0]    xc3_reg, xc4_reg, xc5_reg;
    logic [33:0]   pttt, puut, puuu;
    logic [24:0]   pxc;

    logic [16:0]   pr4_reg, pg4_reg, pb4_reg;
    logic [33:0]   ppr, ppg, ppb;

    logic [7:0]    sr5_reg, sg5_reg, sb5_reg, sr5_next, sg5_next, sb5_next;
    logic [28:0]   mr, mg;
    logic [29:0]   mb;

    logic [7:0]    red_reg, green_reg, blue_reg, red_next, green_next, blue_next;

    // clamp the quotient
    always_comb
    begin
        t1_next   = (din.ovf || din.quo > ecc_pkg::ONE_Q16) ? ecc_pkg::ONE_Q16 : din.quo;
        lin1_next = (din.ovf || din.quo > 17'd255) ? 8'd255 : din.quo[7:0];
    end

    // hue sector and squares
    assign u2_next = ecc_pkg::ONE_Q16 - t1_reg;
    assign h       = 20'(t1_reg) * 20'd6;
    assign x2_next = h[16] ? (ecc_pkg::ONE_Q16 - {1'b0, h[15:0]}) : {1'b0, h[15:0]};
    assign ptt     = t1_reg * t1_reg;
    assign puu     = u2_next * u2_next;

    // cubes and hue channel scale
    assign pttt = tt2_reg * t2_reg;
    assign puut = uu2_reg * t2_reg;
    assign puuu = uu2_reg * u2_reg;
    assign pxc  = x2_reg * 8'd255;

    // fourth factor
    assign ppr = ttt3_reg * u3_reg;
    assign ppg = uut3_reg * t3_reg;
    assign ppb = uuu3_reg * t3_reg;

    // channel weights with saturation
    assign mr = pr4_reg * 12'd2295;
    assign mg = pg4_reg * 12'd3825;
    assign mb = pb4_reg * 13'd4335;
    assign sr5_next = (mr[28:16] > 13'd255) ? 8'd255 : mr[23:16];
    assign sg5_next = (mg[28:16] > 13'd255) ? 8'd255 : mg[23:16];
    assign sb5_next = (mb[29:17] > 13'd255) ? 8'd255 : mb[24:17];

    always_comb
    begin
        red_next   = 8'd0;
        green_next = 8'd0;
        blue_next  = 8'd0;
        if (!tag5_reg.black)
        begin
            unique case (tag5_reg.kind)
                ecc_pkg::KIND_LIN:
                begin
                    red_next   = lin5_reg;
                    green_next = lin5_reg;
                    blue_next  = 8'd255;
                end
                ecc_pkg::KIND_LOG:
                begin
                    unique case (sec5_reg)
                        3'd0:
                        begin
                            red_next   = 8'd255;
                            green_next = xc5_reg;
                        end
                        3'd1:
                        begin
                            red_next   = xc5_reg;
                            green_next = 8'd255;
                        end
                        3'd2:
                        begin
                            green_next = 8'd255;
                            blue_next  = xc5_reg;
                        end
                        3'd3:
                        begin
                            green_next = xc5_reg;
                            blue_next  = 8'd255;
                        end
                        3'd4:
                        begin
                            red_next   = xc5_reg;
                            blue_next  = 8'd255;
                        end
                        // top sector and full ratio share one layout
                        default:
                        begin
                            red_next   = 8'd255;
                            blue_next  = xc5_reg;
                        end
                    endcase
                end
                ecc_pkg::KIND_SMOOTH:
                begin
                    red_next   = sr5_reg;
                    green_next = sg5_reg;
                    blue_next  = sb5_reg;
                end
                ecc_pkg::KIND_CYC:
                begin
                    red_next   = ecc_pkg::CYC_R[tag5_reg.cyc_idx];
                    green_next = ecc_pkg::CYC_G[tag5_reg.cyc_idx];
                    blue_next  = ecc_pkg::CYC_B[tag5_reg.cyc_idx];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= din_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg  <= din.tag;
            t1_reg    <= t1_next;
            lin1_reg  <= lin1_next;

            tag2_reg  <= tag1_reg;
            lin2_reg  <= lin1_reg;
            t2_reg    <= t1_reg;
            u2_reg    <= u2_next;
            tt2_reg   <= ptt[32:16];
            uu2_reg   <= puu[32:16];
            sec2_reg  <= h[18:16];
            x2_reg    <= x2_next;

            tag3_reg  <= tag2_reg;
            lin3_reg  <= lin2_reg;
            sec3_reg  <= sec2_reg;
            t3_reg    <= t2_reg;
            u3_reg    <= u2_reg;
            ttt3_reg  <= pttt[32:16];
            uut3_reg  <= puut[32:16];
            uuu3_reg  <= puuu[32:16];
            xc3_reg   <= pxc[23:16];

            tag4_reg  <= tag3_reg;
            lin4_reg  <= lin3_reg;
            sec4_reg  <= sec3_reg;
            xc4_reg   <= xc3_reg;
            pr4_reg   <= ppr[32:16];
            pg4_reg   <= ppg[32:16];
            pb4_reg   <= ppb[32:16];

            tag5_reg  <= tag4_reg;
            lin5_reg  <= lin4_reg;
            sec5_reg  <= sec4_reg;
            xc5_reg   <= xc4_reg;
            sr5_reg   <= sr5_next;
            sg5_reg   <= sg5_next;
            sb5_reg   <= sb5_next;

            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = v6_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    `ECC_ASSERT_IMP(a_ratio_clamped, v1_reg, t1_reg <= ecc_pkg::ONE_Q16,
        "ratio above one after clamp")
    `ECC_ASSERT_IMP(a_sector_range, v2_reg && tag2_reg.kind == ecc_pkg::KIND_LOG,
        sec2_reg <= 3'd6, "hue sector out of range")

endmodule

@@ src/escape_count_colorizer.sv @@
// top level of the escape count colourizer: registers, front, divider, back
// depends on ecc_pkg, ecc_if, ecc_regs, ecc_front, ecc_div, ecc_back
//
//  channel   dir   payload                                 handshake
//  pix_in    in    iteration_count, magnitude_squared      valid / ready
//  pix_out   out   red, green, blue                        valid / ready
//  apb       in    color_mode, max_iterations registers    psel / penable
//
// one word per clock while the output is taken; seven front stages
// (log2 encode and shift, smooth log chain, operand select, overflow),
// seventeen divider stages of one quotient bit each, six colour stages.
// reset clears every valid bit and loads the registers to mode 0, limit 256.
// when the output word is not taken the whole pipe holds and pix_in.ready drops.
module escape_count_colorizer (
    input  logic         clk,
    input  logic         rst_n,
    ecc_in_if.sink       pix_in,
    ecc_out_if.source    pix_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ecc_pkg::cfg_t     cfg;
    ecc_pkg::div_in_t  div_in;
    ecc_pkg::div_out_t div_out;
    logic              div_in_valid;
    logic              div_out_valid;
    logic              out_valid;
    logic              en;

    assign en           = !out_valid || pix_out.ready;
    assign pix_in.ready = en;
    assign pix_out.valid = out_valid;

    ecc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (pix_in.valid),
        .iteration_count   (pix_in.iteration_count),
        .magnitude_squared (pix_in.magnitude_squared),
        .cfg               (cfg),
        .dout_valid        (div_in_valid),
        .dout              (div_in)
    );

    ecc_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .din_valid  (div_in_valid),
        .din        (div_in),
        .dout_valid (div_out_valid),
        .dout       (div_out)
    );

    ecc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .din_valid (div_out_valid),
        .din       (div_out),
        .out_valid (out_valid),
        .red       (pix_out.red),
        .green     (pix_out.green),
        .blue      (pix_out.blue)
    );

endmodule

@@ bench/tb_escape_count_colorizer.sv @@
// self-checking bench for escape_count_colorizer: a directed table, then random phases
// needs ecc_pkg, ecc_if and the colourizer rtl; checks rgb words against table colours or its own predictor
`timescale 1ns / 1ps

module tb_escape_count_colorizer;

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam logic [2:0] ADDR_COLOR_MODE = 3'd0;
    localparam logic [2:0] ADDR_MAX_ITER   = 3'd4;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 115;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] limit;
        logic [15:0] count;
        logic [31:0] mag;
        logic        typed;
        rgb_t        colour;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ecc_in_if  pix_in ();
    ecc_out_if pix_out ();

    escape_count_colorizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in.sink),
        .pix_out (pix_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [2:0]  cur_mode;
    logic [15:0] cur_limit;
    rgb_t        pending_colours[$];
    int          error_count;
    int          words_in;
    int          words_out;
    int          stall_cycles;
    bit          held_off;

    row_t directed[] = '{
        '{ecc_pkg::MODE_LINEAR, 16'd256, 16'd0, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd255}},
        '{ecc_pkg::MODE_LINEAR, 16'd256, 16'd256, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
        '{ecc_pkg::MODE_LINEAR, 16'd256, 16'd255, 32'd0, 1'b1, '{8'd254, 8'd254, 8'd255}},
        '{ecc_pkg::MODE_LINEAR, 16'd256, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
          '{8'd255, 8'd255, 8'd255}},
        '{ecc_pkg::MODE_HIST, 16'd256, 16'd128, 32'd0, 1'b1, '{8'd127, 8'd127, 8'd255}},
        '{MODE_SPARE5, 16'd256, 16'd64, 32'd5, 1'b0, '0},
        '{MODE_SPARE6, 16'd256, 16'd200, 32'd0, 1'b0, '0},
        '{MODE_SPARE7, 16'd256, 16'd1, 32'd0, 1'b0, '0},
        '{ecc_pkg::MODE_LOG, 16'd256, 16'd0, 32'd0, 1'b1, '{8'd255, 8'd0, 8'd0}},
        '{ecc_pkg::MODE_LOG, 16'd256, 16'd16, 32'd0, 1'b0, '0},
        '{ecc_pkg::MODE_LOG, 16'd256, 16'hFFFF, 32'd0, 1'b1, '{8'd255, 8'd0, 8'd0}},
        '{ecc_pkg::MODE_LOG, 16'd1, 16'd0, 32'd0, 1'b0, '0},
        '{ecc_pkg::MODE_LOG, 16'd1, 16'd2, 32'd0, 1'b0, '0},
        '{ecc_pkg::MODE_LOG, 16'd1, 16'd1, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
        '{ecc_pkg::MODE_LINEAR, 16'd0, 16'd0, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
        '{ecc_pkg::MODE_LINEAR, 16'd0, 16'd5, 32'd0, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{ecc_pkg::MODE_SMOOTH, 16'd256, 16'd10, 32'h01000000, 1'b0, '0},
        '{ecc_pkg::MODE_SMOOTH, 16'd256, 16'd10, 32'h01000001, 1'b0, '0},
        '{ecc_pkg::MODE_SMOOTH, 16'd256, 16'd10, 32'hFFFFFFFF, 1'b0, '0},
        '{ecc_pkg::MODE_SMOOTH, 16'd256, 16'hFFFF, 32'h04000000, 1'b0, '0},
        '{ecc_pkg::MODE_SMOOTH, 16'd0, 16'd3, 32'h04000000, 1'b0, '0},
        '{ecc_pkg::MODE_CYCLIC, 16'd256, 16'd0, 32'd0, 1'b1, '{8'd128, 8'd237, 8'd18}},
        '{ecc_pkg::MODE_CYCLIC, 16'd256, 16'd15, 32'd0, 1'b0, '0},
        '{ecc_pkg::MODE_CYCLIC, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1, '{8'd0, 8'd0, 8'd0}}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // piecewise-linear log2 in Q.16
    function automatic longint unsigned log2_fixed(input longint unsigned x);
        int p;
        if (x == 0)
            return 0;
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0)
            p++;
        return (longint'(p) << 16) + (((x - (64'd1 << p)) << 16) >> p);
    endfunction

    function automatic longint unsigned clip255(input longint unsigned v);
        return v > 255 ? 255 : v;
    endfunction

    function automatic rgb_t pixel_colour(input logic [15:0] count, input logic [31:0] mag);
        longint unsigned i, mx, den, lm, ratio, h, sec, f, x, xc, l2, lnz, t, u, p;
        longint          nu, s;
        rgb_t            c;
        i = count;
        mx = cur_limit;
        den = (mx == 0) ? 1 : mx;
        c = '0;
        if (i == mx)
            c = '0;
        else if (cur_mode == ecc_pkg::MODE_LOG)
        begin
            lm = log2_fixed(mx);
            if (i == 0)
                ratio = 0;
            else if (lm == 0)
                ratio = (i <= 1) ? 0 : 65536;
            else
                ratio = (log2_fixed(i) << 16) / lm;
            if (ratio > 65536)
                ratio = 65536;
            h = ratio * 6;
            sec = h >> 16;
            f = h & 64'hFFFF;
            x = sec[0] ? 65536 - f : f;
            xc = clip255((x * 255) >> 16);
            case (sec)
                0: c = '{8'd255, 8'(xc), 8'd0};
                1: c = '{8'(xc), 8'd255, 8'd0};
                2: c = '{8'd0, 8'd255, 8'(xc)};
                3: c = '{8'd0, 8'(xc), 8'd255};
                4: c = '{8'(xc), 8'd0, 8'd255};
                default: c = '{8'd255, 8'd0, 8'(xc)};
            endcase
        end
        else if (cur_mode == ecc_pkg::MODE_SMOOTH)
        begin
            nu = 0;
            if (mag > 32'h01000000)
            begin
                l2 = log2_fixed(mag) - (64'd24 << 16);
                lnz = (l2 * 22713) >> 16;
                // a log that truncates to nothing still counts as one lsb
                if (lnz == 0)
                    lnz = 1;
                nu = longint'(log2_fixed(lnz)) - (longint'(16) << 16);
            end
            s = longint'((i + 1) << 16) - nu;
            t = (s <= 0) ? 0 : longint'(unsigned'(s)) / den;
            if (t > 65536)
                t = 65536;
            u = 65536 - t;
            p = (((((t * t) >> 16) * t) >> 16) * u) >> 16;
            c.red = 8'(clip255((p * 2295) >> 16));
            p = (((((u * u) >> 16) * t) >> 16) * t) >> 16;
            c.green = 8'(clip255((p * 3825) >> 16));
            p = (((((u * u) >> 16) * u) >> 16) * t) >> 16;
            c.blue = 8'(clip255((p * 4335) >> 17));
        end
        else if (cur_mode == ecc_pkg::MODE_CYCLIC)
            c = '{ecc_pkg::CYC_R[i[3:0]], ecc_pkg::CYC_G[i[3:0]], ecc_pkg::CYC_B[i[3:0]]};
        else
        begin
            c.red = 8'(clip255((i * 255) / den));
            c.green = c.red;
            c.blue = 8'd255;
        end
        return c;
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch on %s at word %0d: got %0d, expected %0d",
                 what, words_out, got, want);
        error_count++;
    endtask

    // setup and access phases; the caller closes the transfer
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_COLOR_MODE)
            cur_mode = value[2:0];
        else
            cur_limit = value[15:0];
    endtask

    task automatic set_colouring(input logic [2:0] mode, input logic [15:0] limit);
        while (pending_colours.size() != 0)
            @(posedge clk);
        reg_write(ADDR_COLOR_MODE, {29'd0, mode});
        reg_write(ADDR_MAX_ITER, {16'd0, limit});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(input logic [15:0] count, input logic [31:0] mag,
                              input bit typed, input rgb_t colour);
        int   gap;
        rgb_t want_colour;
        gap = gap_len();
        if (gap != 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.iteration_count <= count;
        pix_in.magnitude_squared <= mag;
        do
            @(posedge clk);
        while (!pix_in.ready);
        want_colour = typed ? colour : pixel_colour(count, mag);
        pending_colours = {pending_colours, want_colour};
        words_in++;
    endtask

    // receiver: random runs of ready, one long hold-off once more than 300 words have come out
    initial
    begin
        pix_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && words_out > 300)
            begin
                held_off = 1'b1;
                pix_out.ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                               : $urandom_range(1, 6)) @(posedge clk);
            pix_out.ready <= 1'b0;
            repeat (gap_len() + 1) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (pending_colours.size() == 0)
            begin
                $display("unexpected word at output: %0d %0d %0d",
                         pix_out.red, pix_out.green, pix_out.blue);
                error_count++;
            end
            else
            begin
                rgb_t want;
                want = pending_colours.pop_front();
                if (pix_out.red !== want.red)
                    report("red", pix_out.red, want.red);
                if (pix_out.green !== want.green)
                    report("green", pix_out.green, want.green);
                if (pix_out.blue !== want.blue)
                    report("blue", pix_out.blue, want.blue);
            end
            words_out++;
        end
    end

    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            stall_cycles = 0;
        else if (rst_n && (pending_colours.size() != 0 || pix_in.valid))
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_escape_count_colorizer: errors");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]  mode;
        logic [15:0] limit, count;
        logic [31:0] mag;
        int          roll;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_in.valid = 1'b0;
        pix_in.iteration_count = '0;
        pix_in.magnitude_squared = '0;
        cur_mode = ecc_pkg::MODE_LINEAR;
        cur_limit = 16'd256;
        error_count = 0;
        words_in = 0;
        words_out = 0;
        stall_cycles = 0;
        held_off = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the reset values of the registers
        foreach (directed[k])
        begin
            if (directed[k].mode != cur_mode || directed[k].limit != cur_limit)
            begin
                pix_in.valid <= 1'b0;
                set_colouring(directed[k].mode, directed[k].limit);
            end
            send_pixel(directed[k].count, directed[k].mag, directed[k].typed,
                       directed[k].colour);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                mode = ecc_pkg::MODE_LINEAR;
            else if (ph == 1)
                mode = ecc_pkg::MODE_LOG;
            else if (ph <= 4)
                mode = 3'(ph);
            else
                mode = 3'($urandom_range(0, 7));
            case (ph % 4)
                0: limit = 16'hFFFF;
                1: limit = (ph == 1) ? 16'd1 : 16'($urandom_range(1, 65535));
                default: limit = 16'($urandom_range(1, 300));
            endcase
            pix_in.valid <= 1'b0;
            set_colouring(mode, limit);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    count = 16'($urandom_range(0, limit));
                else if (roll < 8)
                    count = limit;
                else
                    count = 16'($urandom);
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    mag = $urandom;
                else if (roll < 7)
                    mag = $urandom_range(0, 32'h04000000);
                else
                    mag = 32'h01000000 + $urandom_range(0, 4096);
                send_pixel(count, mag, 1'b0, '0);
            end
        end
        pix_in.valid <= 1'b0;

        while (pending_colours.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d pixels: a directed table and %0d random colour settings",
                 words_in, RANDOM_PHASES);
        $display("output stalled once for a long stretch; %0d mismatches", error_count);
        if (error_count == 0)
            $display("tb_escape_count_colorizer: clean");
        else
            $display("tb_escape_count_colorizer: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ecc_pkg.sv
src/ecc_if.sv
src/ecc_regs.sv
src/ecc_front.sv
src/ecc_div.sv
src/ecc_back.sv
src/escape_count_colorizer.sv
bench/tb_escape_count_colorizer.sv
